### rtl/speq_pkg.sv
// Shared types, constants and helper functions of the stereo peaking equalizer.
// Used by every other file of the block; depends on nothing.
package speq_pkg;

    localparam int IO_W       = 28;
    localparam int CFG_SLOTS  = 6;
    localparam int BAND_W     = 4;
    localparam int DEN_W      = 36;
    localparam int DIV_STEPS  = 64;
    localparam int PADDR_W    = 6;
    localparam int PDATA_W    = 64;

    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [36:0] ONE_Q30    = 37'h0_4000_0000;
    localparam logic [63:0] COEF_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [15:0] FC_MIN     = 16'd20;

    localparam logic [2:0] TAP_LAST  = 3'd5;
    localparam logic [2:0] COEF_LAST = 3'd4;

    localparam logic [2:0] REG_GAIN     = 3'd0;
    localparam logic [2:0] REG_FREQ_LO  = 3'd1;
    localparam logic [2:0] REG_FREQ_HI  = 3'd2;
    localparam logic [2:0] REG_BANDS    = 3'd3;
    localparam logic [2:0] REG_RATE     = 3'd4;

    localparam logic [17:0] RATE_RESET = 18'd44100;

    typedef struct packed {
        logic              mode;
        logic signed [27:0] left_sample;
        logic signed [27:0] right_sample;
        logic              clear_history;
        logic              end_of_block;
    } in_item_t;

    typedef struct packed {
        logic signed [27:0] left_out;
        logic signed [27:0] right_out;
        logic              block_end;
    } out_item_t;

    typedef struct packed {
        logic [35:0] gain;
        logic [47:0] freq_lo;
        logic [47:0] freq_hi;
        logic [2:0]  bands_used;
        logic [17:0] fs;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR_HIST,
        OP_ACCEPT,
        OP_DER_BAND,
        OP_FDIV_START,
        OP_F_LATCH,
        OP_MUL_T,
        OP_LATCH_T,
        OP_MUL_TF,
        OP_LATCH_K,
        OP_MUL_KK,
        OP_LATCH_K2,
        OP_LATCH_V0,
        OP_CDIV_START,
        OP_C_LATCH,
        OP_MAC,
        OP_ROUND,
        OP_CH_END,
        OP_LOAD_OUT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DER_BAND,
        ST_DER_FDIV,
        ST_DER_FWAIT,
        ST_DER_MT,
        ST_DER_LT,
        ST_DER_MTF,
        ST_DER_LK,
        ST_DER_MKK,
        ST_DER_LK2,
        ST_DER_LV0,
        ST_DER_CDIV,
        ST_DER_CWAIT,
        ST_RUN_BAND,
        ST_RUN_MAC,
        ST_RUN_RND,
        ST_CH_END,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [BAND_W-1:0] band;
        logic [2:0]       tap;
        logic             ch;
    } cmd_t;

    typedef struct packed {
        logic band_ok;
        logic band_on;
        logic div_done;
        logic stereo;
        logic out_full;
    } sts_t;

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63]) begin
            add_sat = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            add_sat = sum[63:0];
        end
    endfunction

endpackage

### rtl/speq_div.sv
// Restoring divider, one quotient bit per cycle, for coefficient derivation.
// Depends on speq_pkg for its widths.
module speq_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [63:0]                  num,
    input  logic [speq_pkg::DEN_W-1:0]   den,
    output logic                         done,
    output logic [63:0]                  quot
);

    logic [speq_pkg::DEN_W-1:0] rem_reg;
    logic [speq_pkg::DEN_W-1:0] den_reg;
    logic [63:0]                quo_reg;
    logic [6:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [speq_pkg::DEN_W:0]   rem_sh;
    logic [speq_pkg::DEN_W:0]   rem_sub;
    logic                       q_bit;

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[63]};
        q_bit   = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= q_bit ? rem_sub[speq_pkg::DEN_W-1:0] : rem_sh[speq_pkg::DEN_W-1:0];
                quo_reg <= {quo_reg[62:0], q_bit};
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(speq_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### rtl/speq_dp.sv
// Datapath: coefficient derivation, shared multiplier and accumulator, history and output register.
// Depends on speq_pkg and speq_div; driven by commands from speq_ctrl.
module speq_dp #(
    parameter int BANDS          = 6,
    parameter int SAMPLE_BITS    = 28,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  speq_pkg::cmd_t       cmd,
    input  speq_pkg::cfg_t       cfg,
    input  speq_pkg::in_item_t   s_data,
    input  logic                 m_ready,
    output speq_pkg::sts_t       sts,
    output logic                 m_valid,
    output speq_pkg::out_item_t  m_data
);

    localparam int BIDX_W = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int ROWS   = 2 * BANDS;
    localparam int RIDX_W = $clog2(ROWS);
    localparam logic signed [63:0] SMAX  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN  = -SMAX - 64'sd1;
    localparam logic signed [63:0] IOMAX = (64'sd1 <<< (speq_pkg::IO_W - 1)) - 64'sd1;
    localparam logic signed [63:0] IOMIN = -IOMAX - 64'sd1;
    localparam logic signed [63:0] RND_C = 64'sd1 <<< (COEF_FRAC_BITS - 1);

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sw(input logic signed [63:0] v);
        if (v > SMAX) begin
            sat_sw = SMAX[SAMPLE_BITS-1:0];
        end else if (v < SMIN) begin
            sat_sw = SMIN[SAMPLE_BITS-1:0];
        end else begin
            sat_sw = v[SAMPLE_BITS-1:0];
        end
    endfunction

    function automatic logic signed [speq_pkg::IO_W-1:0] sat_io(input logic signed [63:0] v);
        if (v > IOMAX) begin
            sat_io = IOMAX[speq_pkg::IO_W-1:0];
        end else if (v < IOMIN) begin
            sat_io = IOMIN[speq_pkg::IO_W-1:0];
        end else begin
            sat_io = v[speq_pkg::IO_W-1:0];
        end
    endfunction

    speq_pkg::in_item_t            in_reg;
    speq_pkg::out_item_t           out_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [27:0]            left_reg;
    logic signed [27:0]            right_reg;
    logic signed [63:0]            acc_reg;
    logic signed [63:0]            prod_reg;
    logic signed [SAMPLE_BITS-1:0] x1_reg [ROWS];
    logic signed [SAMPLE_BITS-1:0] x2_reg [ROWS];
    logic signed [SAMPLE_BITS-1:0] y1_reg [ROWS];
    logic signed [SAMPLE_BITS-1:0] y2_reg [ROWS];
    logic signed [31:0]            coef_reg [BANDS][5];
    logic [BANDS-1:0]              active_reg;
    logic [29:0]                   f_reg;
    logic [31:0]                   t_reg;
    logic [31:0]                   k_reg;
    logic [33:0]                   k2_reg;
    logic [31:0]                   v0k_reg;

    logic [BIDX_W-1:0]             bi;
    logic [RIDX_W-1:0]             row;
    logic [2:0]                    tap_c;
    logic [5:0]                    n_sel;
    logic [15:0]                   fc_sel;
    logic                          band_ok;
    logic signed [32:0]            mul_a;
    logic signed [32:0]            mul_b;
    logic signed [65:0]            mul_full;
    logic signed [63:0]            mul_p;
    logic signed [36:0]            num_sel;
    logic [36:0]                   mag;
    logic [36:0]                   den_d;
    logic [63:0]                   div_num;
    logic [speq_pkg::DEN_W-1:0]    div_den;
    logic                          div_start;
    logic                          div_done;
    logic [63:0]                   div_q;
    logic [30:0]                   q_mag;
    logic signed [63:0]            rnd_sum;
    logic signed [63:0]            y_shift;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    assign bi    = cmd.band[BIDX_W-1:0];
    assign row   = cmd.ch ? (RIDX_W'(BANDS) + RIDX_W'(bi)) : RIDX_W'(bi);
    assign tap_c = (cmd.tap > speq_pkg::COEF_LAST) ? speq_pkg::COEF_LAST : cmd.tap;

    always_comb begin
        n_sel  = '0;
        fc_sel = '0;
        for (int j = 0; j < speq_pkg::CFG_SLOTS; j++) begin
            if (cmd.band == speq_pkg::BAND_W'(j)) begin
                n_sel = cfg.gain[6*j +: 6];
                if (j < 3) begin
                    fc_sel = cfg.freq_lo[16*j +: 16];
                end else begin
                    fc_sel = cfg.freq_hi[16*(j-3) +: 16];
                end
            end
        end
        band_ok = (cmd.band < speq_pkg::BAND_W'(speq_pkg::CFG_SLOTS))
                  && (cmd.band < {1'b0, cfg.bands_used})
                  && (fc_sel > speq_pkg::FC_MIN)
                  && (n_sel != 6'd0)
                  && ((21'(fc_sel) * 21'd20) <= (22'(cfg.fs) * 22'd9));
    end

    always_comb begin
        case (cmd.op)
            speq_pkg::OP_MUL_T: begin
                mul_a = 33'(f_reg);
                mul_b = 33'(speq_pkg::PI_Q30);
            end
            speq_pkg::OP_MUL_TF: begin
                mul_a = 33'(t_reg);
                mul_b = 33'(f_reg);
            end
            speq_pkg::OP_MUL_KK: begin
                mul_a = 33'(k_reg);
                mul_b = 33'(k_reg);
            end
            speq_pkg::OP_LATCH_K2: begin
                mul_a = 33'(k_reg);
                mul_b = 33'(7'd64 + 7'(n_sel));
            end
            default: begin
                mul_a = 33'(coef_reg[bi][tap_c]);
                case (cmd.tap)
                    3'd1:    mul_b = 33'(x1_reg[row]);
                    3'd2:    mul_b = 33'(x2_reg[row]);
                    3'd3:    mul_b = 33'(y1_reg[row]);
                    3'd4:    mul_b = 33'(y2_reg[row]);
                    default: mul_b = 33'(x_reg);
                endcase
            end
        endcase
        mul_full = mul_a * mul_b;
        mul_p    = mul_full[63:0];
    end

    always_comb begin
        den_d = speq_pkg::ONE_Q30 + 37'(k_reg[31:1]) + 37'(k2_reg);
        case (cmd.tap)
            3'd0:    num_sel = signed'(speq_pkg::ONE_Q30 + 37'(v0k_reg) + 37'(k2_reg));
            3'd1:    num_sel = signed'((37'(k2_reg) - speq_pkg::ONE_Q30) << 1);
            3'd2:    num_sel = signed'(speq_pkg::ONE_Q30 + 37'(k2_reg) - 37'(v0k_reg));
            3'd3:    num_sel = -signed'((37'(k2_reg) - speq_pkg::ONE_Q30) << 1);
            default: num_sel = signed'(37'(k_reg[31:1]) - speq_pkg::ONE_Q30 - 37'(k2_reg));
        endcase
        mag = num_sel[36] ? 37'(-num_sel) : 37'(num_sel);
        if (cmd.op == speq_pkg::OP_FDIV_START) begin
            div_num = {18'd0, fc_sel, 30'd0};
            div_den = speq_pkg::DEN_W'(cfg.fs);
        end else begin
            div_num = (64'(mag) << COEF_FRAC_BITS) + 64'(den_d >> 1);
            div_den = speq_pkg::DEN_W'(den_d);
        end
        div_start = (cmd.op == speq_pkg::OP_FDIV_START) || (cmd.op == speq_pkg::OP_CDIV_START);
        q_mag     = (div_q > speq_pkg::COEF_LIMIT) ? 31'h7FFF_FFFF : div_q[30:0];
    end

    always_comb begin
        rnd_sum = speq_pkg::add_sat(acc_reg, RND_C);
        y_shift = rnd_sum >>> COEF_FRAC_BITS;
        y_sat   = sat_sw(y_shift);
    end

    speq_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == speq_pkg::OP_LOAD_OUT) begin
            out_valid_reg <= 1'b1;
        end else if (out_valid_reg && m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= '0;
            for (int r = 0; r < ROWS; r++) begin
                x1_reg[r] <= '0;
                x2_reg[r] <= '0;
                y1_reg[r] <= '0;
                y2_reg[r] <= '0;
            end
        end else begin
            case (cmd.op)
                speq_pkg::OP_CLEAR_HIST: begin
                    for (int r = 0; r < ROWS; r++) begin
                        x1_reg[r] <= '0;
                        x2_reg[r] <= '0;
                        y1_reg[r] <= '0;
                        y2_reg[r] <= '0;
                    end
                end
                speq_pkg::OP_ACCEPT: begin
                    in_reg <= s_data;
                    x_reg  <= sat_sw(64'(s_data.left_sample));
                    if (s_data.clear_history) begin
                        for (int r = 0; r < ROWS; r++) begin
                            x1_reg[r] <= '0;
                            x2_reg[r] <= '0;
                            y1_reg[r] <= '0;
                            y2_reg[r] <= '0;
                        end
                    end
                end
                speq_pkg::OP_DER_BAND:  active_reg[bi] <= band_ok;
                speq_pkg::OP_F_LATCH:   f_reg <= div_q[29:0];
                speq_pkg::OP_MUL_T:     prod_reg <= mul_p;
                speq_pkg::OP_LATCH_T:   t_reg <= prod_reg[61:30];
                speq_pkg::OP_MUL_TF:    prod_reg <= mul_p;
                speq_pkg::OP_LATCH_K:   k_reg <= t_reg + prod_reg[61:30];
                speq_pkg::OP_MUL_KK:    prod_reg <= mul_p;
                speq_pkg::OP_LATCH_K2: begin
                    k2_reg   <= prod_reg[63:30];
                    prod_reg <= mul_p;
                end
                speq_pkg::OP_LATCH_V0:  v0k_reg <= prod_reg[38:7];
                speq_pkg::OP_C_LATCH: begin
                    coef_reg[bi][tap_c] <= num_sel[36] ? -signed'({1'b0, q_mag})
                                                       : signed'({1'b0, q_mag});
                end
                speq_pkg::OP_MAC: begin
                    if (cmd.tap != speq_pkg::TAP_LAST) begin
                        prod_reg <= mul_p;
                    end
                    if (cmd.tap == 3'd1) begin
                        acc_reg <= prod_reg;
                    end else if (cmd.tap > 3'd1) begin
                        acc_reg <= speq_pkg::add_sat(acc_reg, prod_reg);
                    end
                end
                speq_pkg::OP_ROUND: begin
                    x2_reg[row] <= x1_reg[row];
                    x1_reg[row] <= x_reg;
                    y2_reg[row] <= y1_reg[row];
                    y1_reg[row] <= y_sat;
                    x_reg       <= y_sat;
                end
                speq_pkg::OP_CH_END: begin
                    if (!cmd.ch) begin
                        left_reg <= sat_io(64'(x_reg));
                        if (in_reg.mode) begin
                            x_reg <= sat_sw(64'(in_reg.right_sample));
                        end
                    end else begin
                        right_reg <= sat_io(64'(x_reg));
                    end
                end
                speq_pkg::OP_LOAD_OUT: begin
                    out_reg.left_out  <= left_reg;
                    out_reg.right_out <= in_reg.mode ? right_reg : in_reg.right_sample;
                    out_reg.block_end <= in_reg.end_of_block;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sts.band_ok  = band_ok;
        sts.band_on  = active_reg[bi];
        sts.div_done = div_done;
        sts.stereo   = in_reg.mode;
        sts.out_full = out_valid_reg && !m_ready;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### rtl/speq_ctrl.sv
// Controller state machine: sequences coefficient derivation and the per-band filter steps.
// Depends on speq_pkg; issues commands to speq_dp and reads its status.
module speq_ctrl #(
    parameter int BANDS = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            cfg_wr,
    input  speq_pkg::sts_t  sts,
    output logic            s_ready,
    output speq_pkg::cmd_t  cmd
);

    localparam int BIDX_W = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam logic [BIDX_W-1:0] LAST_BAND = BIDX_W'(BANDS - 1);

    speq_pkg::state_t  state_reg, state_next;
    logic [BIDX_W-1:0] band_reg, band_next;
    logic [2:0]        tap_reg, tap_next;
    logic              ch_reg, ch_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= speq_pkg::ST_IDLE;
            band_reg  <= '0;
            tap_reg   <= '0;
            ch_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            band_reg  <= band_next;
            tap_reg   <= tap_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        band_next  = band_reg;
        tap_next   = tap_reg;
        ch_next    = ch_reg;
        cmd.op     = speq_pkg::OP_NONE;
        cmd.band   = speq_pkg::BAND_W'(band_reg);
        cmd.tap    = tap_reg;
        cmd.ch     = ch_reg;
        s_ready    = (state_reg == speq_pkg::ST_IDLE) && !cfg_wr;

        case (state_reg)
            speq_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.op     = speq_pkg::OP_ACCEPT;
                    band_next  = '0;
                    ch_next    = 1'b0;
                    state_next = speq_pkg::ST_RUN_BAND;
                end
            end
            speq_pkg::ST_DER_BAND: begin
                cmd.op = speq_pkg::OP_DER_BAND;
                if (sts.band_ok) begin
                    state_next = speq_pkg::ST_DER_FDIV;
                end else if (band_reg == LAST_BAND) begin
                    state_next = speq_pkg::ST_IDLE;
                end else begin
                    band_next = band_reg + 1'b1;
                end
            end
            speq_pkg::ST_DER_FDIV: begin
                cmd.op     = speq_pkg::OP_FDIV_START;
                state_next = speq_pkg::ST_DER_FWAIT;
            end
            speq_pkg::ST_DER_FWAIT: begin
                if (sts.div_done) begin
                    cmd.op     = speq_pkg::OP_F_LATCH;
                    state_next = speq_pkg::ST_DER_MT;
                end
            end
            speq_pkg::ST_DER_MT: begin
                cmd.op     = speq_pkg::OP_MUL_T;
                state_next = speq_pkg::ST_DER_LT;
            end
            speq_pkg::ST_DER_LT: begin
                cmd.op     = speq_pkg::OP_LATCH_T;
                state_next = speq_pkg::ST_DER_MTF;
            end
            speq_pkg::ST_DER_MTF: begin
                cmd.op     = speq_pkg::OP_MUL_TF;
                state_next = speq_pkg::ST_DER_LK;
            end
            speq_pkg::ST_DER_LK: begin
                cmd.op     = speq_pkg::OP_LATCH_K;
                state_next = speq_pkg::ST_DER_MKK;
            end
            speq_pkg::ST_DER_MKK: begin
                cmd.op     = speq_pkg::OP_MUL_KK;
                state_next = speq_pkg::ST_DER_LK2;
            end
            speq_pkg::ST_DER_LK2: begin
                cmd.op     = speq_pkg::OP_LATCH_K2;
                state_next = speq_pkg::ST_DER_LV0;
            end
            speq_pkg::ST_DER_LV0: begin
                cmd.op     = speq_pkg::OP_LATCH_V0;
                tap_next   = '0;
                state_next = speq_pkg::ST_DER_CDIV;
            end
            speq_pkg::ST_DER_CDIV: begin
                cmd.op     = speq_pkg::OP_CDIV_START;
                state_next = speq_pkg::ST_DER_CWAIT;
            end
            speq_pkg::ST_DER_CWAIT: begin
                if (sts.div_done) begin
                    cmd.op = speq_pkg::OP_C_LATCH;
                    if (tap_reg == speq_pkg::COEF_LAST) begin
                        tap_next = '0;
                        if (band_reg == LAST_BAND) begin
                            state_next = speq_pkg::ST_IDLE;
                        end else begin
                            band_next  = band_reg + 1'b1;
                            state_next = speq_pkg::ST_DER_BAND;
                        end
                    end else begin
                        tap_next   = tap_reg + 3'd1;
                        state_next = speq_pkg::ST_DER_CDIV;
                    end
                end
            end
            speq_pkg::ST_RUN_BAND: begin
                if (sts.band_on) begin
                    tap_next   = '0;
                    state_next = speq_pkg::ST_RUN_MAC;
                end else if (band_reg == LAST_BAND) begin
                    state_next = speq_pkg::ST_CH_END;
                end else begin
                    band_next = band_reg + 1'b1;
                end
            end
            speq_pkg::ST_RUN_MAC: begin
                cmd.op = speq_pkg::OP_MAC;
                if (tap_reg == speq_pkg::TAP_LAST) begin
                    state_next = speq_pkg::ST_RUN_RND;
                end else begin
                    tap_next = tap_reg + 3'd1;
                end
            end
            speq_pkg::ST_RUN_RND: begin
                cmd.op = speq_pkg::OP_ROUND;
                if (band_reg == LAST_BAND) begin
                    state_next = speq_pkg::ST_CH_END;
                end else begin
                    band_next  = band_reg + 1'b1;
                    state_next = speq_pkg::ST_RUN_BAND;
                end
            end
            speq_pkg::ST_CH_END: begin
                cmd.op = speq_pkg::OP_CH_END;
                if (!ch_reg && sts.stereo) begin
                    ch_next    = 1'b1;
                    band_next  = '0;
                    state_next = speq_pkg::ST_RUN_BAND;
                end else begin
                    state_next = speq_pkg::ST_OUT;
                end
            end
            speq_pkg::ST_OUT: begin
                if (!sts.out_full) begin
                    cmd.op     = speq_pkg::OP_LOAD_OUT;
                    state_next = speq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = speq_pkg::ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            cmd.op     = speq_pkg::OP_CLEAR_HIST;
            band_next  = '0;
            tap_next   = '0;
            state_next = speq_pkg::ST_DER_BAND;
        end
    end

endmodule

### rtl/stereo_peaking_equalizer.sv
// From input transfer to result each channel (one for mono, two for stereo) steps through every band;
// each active band runs its taps on the single shared multiplier.
// One item at a time: an input is taken only once the previous result is loaded; its transfer can
// share an edge with the result transfer; a held result stalls the following item in its output step.
// After a register write the coefficients are rederived, and no input is taken meanwhile.
// Reset: synchronous, active low; all bands bypassed, history zeroed, no result pending.
module stereo_peaking_equalizer #(
    parameter int BANDS          = 6,
    parameter int SAMPLE_BITS    = 28,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  speq_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output speq_pkg::out_item_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [speq_pkg::PADDR_W-1:0]    paddr,
    input  logic [speq_pkg::PDATA_W-1:0]    pwdata,
    output logic [speq_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    speq_pkg::cfg_t  cfg_reg;
    speq_pkg::cmd_t  cmd;
    speq_pkg::sts_t  sts;
    logic [2:0]      reg_idx;
    logic            wr_en;
    logic            cfg_wr;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign cfg_wr  = wr_en && (reg_idx <= speq_pkg::REG_RATE);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain       <= '0;
            cfg_reg.freq_lo    <= '0;
            cfg_reg.freq_hi    <= '0;
            cfg_reg.bands_used <= '0;
            cfg_reg.fs         <= speq_pkg::RATE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                speq_pkg::REG_GAIN:    cfg_reg.gain       <= pwdata[35:0];
                speq_pkg::REG_FREQ_LO: cfg_reg.freq_lo    <= pwdata[47:0];
                speq_pkg::REG_FREQ_HI: cfg_reg.freq_hi    <= pwdata[47:0];
                speq_pkg::REG_BANDS:   cfg_reg.bands_used <= pwdata[2:0];
                speq_pkg::REG_RATE:    cfg_reg.fs         <= pwdata[17:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            speq_pkg::REG_GAIN:    prdata = 64'(cfg_reg.gain);
            speq_pkg::REG_FREQ_LO: prdata = 64'(cfg_reg.freq_lo);
            speq_pkg::REG_FREQ_HI: prdata = 64'(cfg_reg.freq_hi);
            speq_pkg::REG_BANDS:   prdata = 64'(cfg_reg.bands_used);
            speq_pkg::REG_RATE:    prdata = 64'(cfg_reg.fs);
            default:               prdata = '0;
        endcase
    end

    speq_ctrl #(
        .BANDS (BANDS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .cfg_wr  (cfg_wr),
        .sts     (sts),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    speq_dp #(
        .BANDS          (BANDS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .m_ready (m_ready),
        .sts     (sts),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item was still in work");

    a_write_starts_derivation: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_ready)
        else $error("input not blocked after a register write");

    a_write_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |-> !s_ready)
        else $error("input offered ready during a register write");

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
